/* design/blit_address_generator_macros.svh */
`ifndef BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define BLIT_ADDRESS_GENERATOR_MACROS_SVH

// Checks that expect signals named clock and reset in the including scope.

// Property that must hold at every edge outside reset.
`define BAG_ASSERT_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define BAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bag_pkg.sv */
`timescale 1ns / 1ps

package bag_pkg;

   // Default coordinate width; sizes carry one more bit
   localparam int BAG_COORD_BITS = 12;

   // Entries in the command queue between front and back
   localparam int BAG_QUEUE_DEPTH = 2;

   // Surface register values after reset
   localparam int BAG_SRC_WIDTH_RESET  = 640;
   localparam int BAG_SRC_HEIGHT_RESET = 480;
   localparam int BAG_DST_WIDTH_RESET  = 640;
   localparam int BAG_DST_HEIGHT_RESET = 480;

   // Mode field codes of an input item
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_COPY    = 2'd1;
   localparam logic [1:0] MODE_STRETCH = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DST_HEIGHT = 2'd3;

   // Kind of a queued entry
   localparam int BAG_KIND_BITS = 2;
   typedef enum logic [BAG_KIND_BITS-1:0] {
      KIND_TICK,
      KIND_COPY,
      KIND_STRETCH
   } bag_kind_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RUN
   } bag_state_type;

   // Back end status seen by the top level
   typedef struct packed {
      logic busy;
      logic dividing;
      logic emit;
      logic finish;
   } bag_status_type;

endpackage

/* design/bag_front.sv */
`timescale 1ns / 1ps

module bag_front import bag_pkg::*; #(
   parameter int COORD_BITS = BAG_COORD_BITS,
   localparam int SizeBits = COORD_BITS + 1,
   localparam int EntryBits = BAG_KIND_BITS + 4 * COORD_BITS + 4 * SizeBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [COORD_BITS-1:0] req_src_x0,
   input  logic [COORD_BITS-1:0] req_src_y0,
   input  logic [SizeBits-1:0]   req_src_w,
   input  logic [SizeBits-1:0]   req_src_h,
   input  logic [COORD_BITS-1:0] req_dst_x0,
   input  logic [COORD_BITS-1:0] req_dst_y0,
   input  logic [SizeBits-1:0]   req_dst_w,
   input  logic [SizeBits-1:0]   req_dst_h,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SizeBits-1:0]   csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [EntryBits-1:0]  q_entry
);

   localparam logic [SizeBits-1:0] SizeLimit = {1'b1, {COORD_BITS{1'b0}}};
   localparam logic [SizeBits-1:0] SrcWReset = (BAG_SRC_WIDTH_RESET > 2**COORD_BITS) ?
      SizeLimit : SizeBits'(BAG_SRC_WIDTH_RESET);
   localparam logic [SizeBits-1:0] SrcHReset = (BAG_SRC_HEIGHT_RESET > 2**COORD_BITS) ?
      SizeLimit : SizeBits'(BAG_SRC_HEIGHT_RESET);
   localparam logic [SizeBits-1:0] DstWReset = (BAG_DST_WIDTH_RESET > 2**COORD_BITS) ?
      SizeLimit : SizeBits'(BAG_DST_WIDTH_RESET);
   localparam logic [SizeBits-1:0] DstHReset = (BAG_DST_HEIGHT_RESET > 2**COORD_BITS) ?
      SizeLimit : SizeBits'(BAG_DST_HEIGHT_RESET);

   logic [SizeBits-1:0] src_surf_w_ff, src_surf_w_in;
   logic [SizeBits-1:0] src_surf_h_ff, src_surf_h_in;
   logic [SizeBits-1:0] dst_surf_w_ff, dst_surf_w_in;
   logic [SizeBits-1:0] dst_surf_h_ff, dst_surf_h_in;

   logic [SizeBits-1:0] csr_value;
   logic [SizeBits-1:0] sw, sh, dw, dh;
   logic [SizeBits-1:0] src_room_x, src_room_y, dst_room_x, dst_room_y;
   logic [SizeBits-1:0] copy_cols_part, copy_rows_part;
   logic [SizeBits-1:0] cols, rows;
   logic                origin_ok, src_size_ok, dst_size_ok;
   logic                keep;
   bag_kind_type        kind;

   function automatic logic [SizeBits-1:0] clamp_size(input logic [SizeBits-1:0] v);
      clamp_size = (v > SizeLimit) ? SizeLimit : v;
   endfunction

   function automatic logic [SizeBits-1:0] min2(input logic [SizeBits-1:0] a,
                                                input logic [SizeBits-1:0] b);
      min2 = (a < b) ? a : b;
   endfunction

   // Hold surface sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_surf_w_ff <= SrcWReset;
         src_surf_h_ff <= SrcHReset;
         dst_surf_w_ff <= DstWReset;
         dst_surf_h_ff <= DstHReset;
      end else begin
         src_surf_w_ff <= src_surf_w_in;
         src_surf_h_ff <= src_surf_h_in;
         dst_surf_w_ff <= dst_surf_w_in;
         dst_surf_h_ff <= dst_surf_h_in;
      end
   end

   // Write a surface register, clamping oversized values
   assign csr_ready = 1'b1;
   assign csr_value = clamp_size(csr_wdata);

   always_comb begin
      src_surf_w_in = src_surf_w_ff;
      src_surf_h_in = src_surf_h_ff;
      dst_surf_w_in = dst_surf_w_ff;
      dst_surf_h_in = dst_surf_h_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_surf_w_in = csr_value;
            CSR_SRC_HEIGHT: src_surf_h_in = csr_value;
            CSR_DST_WIDTH:  dst_surf_w_in = csr_value;
            CSR_DST_HEIGHT: dst_surf_h_in = csr_value;
            default: ;
         endcase
      end
   end

   // Check origins and sizes; clip a copy against both surfaces, a stretch against the destination
   always_comb begin
      sw = clamp_size(req_src_w);
      sh = clamp_size(req_src_h);
      dw = clamp_size(req_dst_w);
      dh = clamp_size(req_dst_h);

      origin_ok = ({1'b0, req_src_x0} < src_surf_w_ff) && ({1'b0, req_src_y0} < src_surf_h_ff)
               && ({1'b0, req_dst_x0} < dst_surf_w_ff) && ({1'b0, req_dst_y0} < dst_surf_h_ff);
      src_size_ok = (sw != '0) && (sh != '0);
      dst_size_ok = (dw != '0) && (dh != '0);

      src_room_x = src_surf_w_ff - {1'b0, req_src_x0};
      src_room_y = src_surf_h_ff - {1'b0, req_src_y0};
      dst_room_x = dst_surf_w_ff - {1'b0, req_dst_x0};
      dst_room_y = dst_surf_h_ff - {1'b0, req_dst_y0};

      copy_cols_part = min2(sw, src_room_x);
      copy_rows_part = min2(sh, src_room_y);

      keep = 1'b0;
      kind = KIND_TICK;
      cols = min2(copy_cols_part, dst_room_x);
      rows = min2(copy_rows_part, dst_room_y);
      case (req_mode)
         MODE_TICK: begin
            keep = 1'b1;
         end
         MODE_COPY: begin
            keep = origin_ok && src_size_ok;
            kind = KIND_COPY;
         end
         MODE_STRETCH: begin
            keep = origin_ok && src_size_ok && dst_size_ok;
            kind = KIND_STRETCH;
            cols = min2(dw, dst_room_x);
            rows = min2(dh, dst_room_y);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Queue what the back end must see; drop rejected and unknown items
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && keep;
   assign q_entry   = {kind, req_src_x0, req_src_y0, req_dst_x0, req_dst_y0,
                       cols, rows, sw, sh};

endmodule

/* design/bag_queue.sv */
`timescale 1ns / 1ps

module bag_queue import bag_pkg::*; #(
   parameter int WIDTH = 8,
   localparam int Depth = BAG_QUEUE_DEPTH,
   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CountBits = $clog2(Depth + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [WIDTH-1:0]     pop_data,
   output logic [CountBits-1:0] count
);

   logic [WIDTH-1:0]     slot_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
      next_ptr = (p == PtrBits'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store an item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CountBits'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* design/bag_divider.sv */
`timescale 1ns / 1ps

module bag_divider #(
   parameter int WIDTH = 13,
   localparam int CountBits = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     quo_ff, quo_in;
   logic [WIDTH-1:0]     div_ff, div_in;
   logic [WIDTH:0]       trial;
   logic [WIDTH:0]       diff;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});

      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = '0;
         rem_in    = '0;
         quo_in    = dividend;
         div_in    = divisor;
      end else if (active_ff) begin
         rem_in   = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         quo_in   = {quo_ff[WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CountBits'(WIDTH - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* design/bag_back.sv */
`timescale 1ns / 1ps

module bag_back import bag_pkg::*; #(
   parameter int COORD_BITS = BAG_COORD_BITS,
   localparam int SizeBits = COORD_BITS + 1,
   localparam int EntryBits = BAG_KIND_BITS + 4 * COORD_BITS + 4 * SizeBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [EntryBits-1:0]  q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SizeBits-1:0]   rsp_src_x,
   output logic [SizeBits-1:0]   rsp_src_y,
   output logic [COORD_BITS-1:0] rsp_dst_x,
   output logic [COORD_BITS-1:0] rsp_dst_y,
   output logic                  rsp_last,
   output bag_status_type        status
);

   // Queued entry
   logic [BAG_KIND_BITS-1:0] e_kind_bits;
   bag_kind_type             e_kind;
   logic [COORD_BITS-1:0]    e_sx, e_sy, e_dx, e_dy;
   logic [SizeBits-1:0]      e_cols, e_rows, e_sw, e_sh;

   assign {e_kind_bits, e_sx, e_sy, e_dx, e_dy, e_cols, e_rows, e_sw, e_sh} = q_data;
   assign e_kind = bag_kind_type'(e_kind_bits);

   bag_state_type         state_ff, state_in;
   logic                  stretch_ff, stretch_in;
   logic [SizeBits-1:0]   col_ff, col_in, row_ff, row_in;
   logic [SizeBits-1:0]   cols_ff, cols_in, rows_ff, rows_in;
   logic [COORD_BITS-1:0] org_sx_ff, org_sx_in, org_sy_ff, org_sy_in;
   logic [COORD_BITS-1:0] org_dx_ff, org_dx_in, org_dy_ff, org_dy_in;
   logic [SizeBits-1:0]   whole_x_ff, whole_x_in, whole_y_ff, whole_y_in;
   logic [SizeBits-1:0]   frac_x_ff, frac_x_in, frac_y_ff, frac_y_in;
   logic [SizeBits-1:0]   err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic [SizeBits-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SizeBits-1:0]   rsp_src_x_ff, rsp_src_x_in, rsp_src_y_ff, rsp_src_y_in;
   logic [COORD_BITS-1:0] rsp_dst_x_ff, rsp_dst_x_in, rsp_dst_y_ff, rsp_dst_y_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  div_start;
   logic                  div_done_x, div_done_y;
   logic [SizeBits-1:0]   quo_x, rem_x, quo_y, rem_y;

   logic                  out_free;
   logic                  emit;
   logic                  row_end, fin;
   logic [SizeBits:0]     col_plus, row_plus;
   logic [SizeBits-1:0]   ox, oy;
   logic [SizeBits:0]     err_sum_x, err_sum_y;
   logic                  carry_x, carry_y;
   logic [SizeBits-1:0]   err_adv_x, err_adv_y, cur_adv_x, cur_adv_y;

   // Setup division, one per axis, run side by side
   assign div_start = (state_ff == ST_IDLE) && q_valid && (e_kind == KIND_STRETCH);

   bag_divider #(.WIDTH(SizeBits)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (e_sw),
      .divisor   (e_cols),
      .done      (div_done_x),
      .quotient  (quo_x),
      .remainder (rem_x)
   );

   bag_divider #(.WIDTH(SizeBits)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (e_sh),
      .divisor   (e_rows),
      .done      (div_done_y),
      .quotient  (quo_y),
      .remainder (rem_y)
   );

   // Position of the current pair and the stepping of each axis
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;

      col_plus = {1'b0, col_ff} + {{SizeBits{1'b0}}, 1'b1};
      row_plus = {1'b0, row_ff} + {{SizeBits{1'b0}}, 1'b1};
      row_end  = (col_plus >= {1'b0, cols_ff});
      fin      = row_end && (row_plus >= {1'b0, rows_ff});

      ox = stretch_ff ? cur_x_ff : col_ff;
      oy = stretch_ff ? cur_y_ff : row_ff;

      err_sum_x = {1'b0, err_x_ff} + {1'b0, frac_x_ff};
      carry_x   = (err_sum_x >= {1'b0, cols_ff});
      err_adv_x = carry_x ? SizeBits'(err_sum_x - {1'b0, cols_ff}) : err_sum_x[SizeBits-1:0];
      cur_adv_x = cur_x_ff + whole_x_ff + {{(SizeBits-1){1'b0}}, carry_x};

      err_sum_y = {1'b0, err_y_ff} + {1'b0, frac_y_ff};
      carry_y   = (err_sum_y >= {1'b0, rows_ff});
      err_adv_y = carry_y ? SizeBits'(err_sum_y - {1'b0, rows_ff}) : err_sum_y[SizeBits-1:0];
      cur_adv_y = cur_y_ff + whole_y_ff + {{(SizeBits-1){1'b0}}, carry_y};
   end

   // Sequencer: next state, queue pop and result register
   always_comb begin
      state_in   = state_ff;
      stretch_in = stretch_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      org_sx_in  = org_sx_ff;
      org_sy_in  = org_sy_ff;
      org_dx_in  = org_dx_ff;
      org_dy_in  = org_dy_ff;
      whole_x_in = whole_x_ff;
      whole_y_in = whole_y_ff;
      frac_x_in  = frac_x_ff;
      frac_y_in  = frac_y_ff;
      err_x_in   = err_x_ff;
      err_y_in   = err_y_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Idle: ticks drop, commands load the run
            q_pop = q_valid;
            if (q_valid && (e_kind != KIND_TICK)) begin
               stretch_in = (e_kind == KIND_STRETCH);
               org_sx_in  = e_sx;
               org_sy_in  = e_sy;
               org_dx_in  = e_dx;
               org_dy_in  = e_dy;
               cols_in    = e_cols;
               rows_in    = e_rows;
               col_in     = '0;
               row_in     = '0;
               err_x_in   = '0;
               err_y_in   = '0;
               cur_x_in   = '0;
               cur_y_in   = '0;
               state_in   = (e_kind == KIND_STRETCH) ? ST_DIVIDE : ST_RUN;
            end
         end
         ST_DIVIDE: begin
            // Hold the queue until the step sizes are known
            if (div_done_x && div_done_y) begin
               whole_x_in = quo_x;
               frac_x_in  = rem_x;
               whole_y_in = quo_y;
               frac_y_in  = rem_y;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            // Busy: commands drop, each tick emits one pair
            q_pop = q_valid && ((e_kind != KIND_TICK) || out_free);
            if (q_valid && (e_kind == KIND_TICK) && out_free) begin
               emit = 1'b1;
               if (fin) begin
                  state_in = ST_IDLE;
               end else if (row_end) begin
                  col_in   = '0;
                  err_x_in = '0;
                  cur_x_in = '0;
                  row_in   = row_plus[SizeBits-1:0];
                  if (stretch_ff) begin
                     err_y_in = err_adv_y;
                     cur_y_in = cur_adv_y;
                  end
               end else begin
                  col_in = col_plus[SizeBits-1:0];
                  if (stretch_ff) begin
                     err_x_in = err_adv_x;
                     cur_x_in = cur_adv_x;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result register: load on emit, drop once taken
      rsp_valid_in = rsp_valid_ff;
      rsp_src_x_in = rsp_src_x_ff;
      rsp_src_y_in = rsp_src_y_ff;
      rsp_dst_x_in = rsp_dst_x_ff;
      rsp_dst_y_in = rsp_dst_y_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_src_x_in = {1'b0, org_sx_ff} + ox;
         rsp_src_y_in = {1'b0, org_sy_ff} + oy;
         rsp_dst_x_in = org_dx_ff + col_ff[COORD_BITS-1:0];
         rsp_dst_y_in = org_dy_ff + row_ff[COORD_BITS-1:0];
         rsp_last_in  = fin;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stretch_ff   <= stretch_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      org_sx_ff    <= org_sx_in;
      org_sy_ff    <= org_sy_in;
      org_dx_ff    <= org_dx_in;
      org_dy_ff    <= org_dy_in;
      whole_x_ff   <= whole_x_in;
      whole_y_ff   <= whole_y_in;
      frac_x_ff    <= frac_x_in;
      frac_y_ff    <= frac_y_in;
      err_x_ff     <= err_x_in;
      err_y_ff     <= err_y_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      rsp_src_x_ff <= rsp_src_x_in;
      rsp_src_y_ff <= rsp_src_y_in;
      rsp_dst_x_ff <= rsp_dst_x_in;
      rsp_dst_y_ff <= rsp_dst_y_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_src_x = rsp_src_x_ff;
   assign rsp_src_y = rsp_src_y_ff;
   assign rsp_dst_x = rsp_dst_x_ff;
   assign rsp_dst_y = rsp_dst_y_ff;
   assign rsp_last  = rsp_last_ff;

   assign status.busy     = (state_ff != ST_IDLE);
   assign status.dividing = (state_ff == ST_DIVIDE);
   assign status.emit     = emit;
   assign status.finish   = emit && fin;

endmodule

/* design/blit_address_generator.sv */
`timescale 1ns / 1ps

// Blit address generator. A copy or stretch command on the req channel is
// checked against the four surface registers and clipped; every tick after
// it gives one source/destination pixel pair on rsp, row by row, with
// rsp_last on the final pair. Commands while a blit runs, ticks while idle,
// rejected commands and mode three give no result. Stretch uses nearest
// neighbor stepping; its source coordinates are not clipped.
// Flow: an item passes a two-entry queue and the result register, which
// presents it on rsp until rsp_ready takes it. While a blit runs and
// rsp_ready is held high, ticks are taken and answered one per cycle. A copy
// command takes the back end from idle straight to running; a stretch command
// first passes a setup state, where a restoring divider per axis computes the
// step sizes one quotient bit per cycle. The front keeps accepting into the
// queue during that setup until the queue is full.

module blit_address_generator import bag_pkg::*; #(
   parameter int COORD_BITS = BAG_COORD_BITS,
   localparam int SizeBits = COORD_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [COORD_BITS-1:0] req_src_x0,
   input  logic [COORD_BITS-1:0] req_src_y0,
   input  logic [SizeBits-1:0]   req_src_w,
   input  logic [SizeBits-1:0]   req_src_h,
   input  logic [COORD_BITS-1:0] req_dst_x0,
   input  logic [COORD_BITS-1:0] req_dst_y0,
   input  logic [SizeBits-1:0]   req_dst_w,
   input  logic [SizeBits-1:0]   req_dst_h,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SizeBits-1:0]   rsp_src_x,
   output logic [SizeBits-1:0]   rsp_src_y,
   output logic [COORD_BITS-1:0] rsp_dst_x,
   output logic [COORD_BITS-1:0] rsp_dst_y,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SizeBits-1:0]   csr_wdata
);

`include "blit_address_generator_macros.svh"

   localparam int EntryBits = BAG_KIND_BITS + 4 * COORD_BITS + 4 * SizeBits;
   localparam int CountBits = $clog2(BAG_QUEUE_DEPTH + 1);

   logic                 q_full;
   logic                 q_push;
   logic [EntryBits-1:0] q_entry;
   logic                 q_pop;
   logic                 q_valid;
   logic [EntryBits-1:0] q_data;
   logic [CountBits-1:0] q_count;
   bag_status_type       back_status;

   // Front: accept, check and clip
   bag_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_src_x0 (req_src_x0),
      .req_src_y0 (req_src_y0),
      .req_src_w  (req_src_w),
      .req_src_h  (req_src_h),
      .req_dst_x0 (req_dst_x0),
      .req_dst_y0 (req_dst_y0),
      .req_dst_w  (req_dst_w),
      .req_dst_h  (req_dst_h),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // Queue between front and back
   bag_queue #(.WIDTH(EntryBits)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .count     (q_count)
   );

   // Back: run the blit and emit pairs
   bag_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_src_x (rsp_src_x),
      .rsp_src_y (rsp_src_y),
      .rsp_dst_x (rsp_dst_x),
      .rsp_dst_y (rsp_dst_y),
      .rsp_last  (rsp_last),
      .status    (back_status)
   );

   // Queue is left alone while the step sizes are being computed
   `BAG_ASSERT_NOW(a_no_pop_in_setup, !(back_status.dividing && q_pop), "pop during setup")
   // An emitted pair is presented on the next cycle
   `BAG_ASSERT_NEXT(a_emit_shows, back_status.emit, rsp_valid, "emitted pair not shown")
   // The final pair returns the back end to idle
   `BAG_ASSERT_NEXT(a_finish_idle, back_status.finish, !back_status.busy && rsp_last, "blit did not end")
   // The queue never reports more entries than it holds
   `BAG_ASSERT_NOW(a_queue_bound, q_count <= CountBits'(BAG_QUEUE_DEPTH), "queue overrun")

endmodule
